// ===== hdl/v3au_pkg.sv =====
// ----------------------------------------------------------------------------
// v3au_pkg: shared definitions for the 3-D vector arithmetic unit
// Component format, derived widths, opcodes, status codes, the record that
// travels down the pipeline, and the saturation helpers.
// ----------------------------------------------------------------------------
package v3au_pkg;

    // Component format: signed fixed point, CW bits with FB fraction bits.
    localparam int CW     = 32;
    localparam int FB     = 16;
    // Guard bits added below the length when normalizing.
    localparam int G      = 64 - CW;
    localparam int NLANE  = 3;

    // Sum of three squares of component magnitudes.
    localparam int SQW    = 2 * CW + 2;
    // Square root datapath: root width, radicand width, partial remainder width.
    localparam int ROOTW  = CW + 1 + G;
    localparam int RADW   = 2 * ROOTW;
    localparam int RW     = ROOTW + 2;
    // Normalize divider: quotient bits before rounding, after rounding, latency.
    localparam int DIVQW  = FB + 1;
    localparam int QW     = DIVQW + 1;
    localparam int DIV_LAT = DIVQW + 2;
    // Width of a magnitude handed to the saturation helper.
    localparam int SATW   = 2 * CW;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_SCALE = 2'd1,
        OP_NORM  = 2'd2,
        OP_PASS  = 2'd3
    } t_op;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    // One item in flight. For normalize, mag holds |a| until the merge stage.
    typedef struct packed {
        t_op                         op;
        logic [NLANE-1:0][CW-1:0]    res;
        logic [NLANE-1:0][CW-1:0]    mag;
        logic [NLANE-1:0]            neg;
        logic                        sat;
        logic                        zero;
    } t_item;

    typedef struct packed {
        logic [NLANE-1:0][CW-1:0]    res;
        logic [CW-1:0]               magnitude;
        logic [1:0]                  status;
    } t_out;

    typedef struct packed {
        logic            sat;
        logic [CW-1:0]   mag;
    } t_sat;

    // Clamp a magnitude to what a signed component of the given sign can hold.
    function automatic t_sat sat_mag(input logic [SATW-1:0] m, input logic neg);
        logic [SATW-1:0] lim;
        t_sat            r;
        lim   = neg ? (SATW'(1) << (CW - 1)) : ((SATW'(1) << (CW - 1)) - SATW'(1));
        r.sat = (m > lim);
        r.mag = r.sat ? lim[CW-1:0] : m[CW-1:0];
        return r;
    endfunction

    function automatic logic [CW-1:0] apply_sign(input logic [CW-1:0] m, input logic neg);
        return neg ? (~m + CW'(1)) : m;
    endfunction

    function automatic logic [CW-1:0] abs_cw(input logic [CW-1:0] x);
        return x[CW-1] ? (~x + CW'(1)) : x;
    endfunction

endpackage

// ===== hdl/v3au_lane.sv =====
// ----------------------------------------------------------------------------
// v3au_lane: front end for one vector component
// Forms the sum, the rounded scaled product and the square of |a| for one
// component, and saturates the selected result. Three pipeline stages.
// ----------------------------------------------------------------------------
module v3au_lane (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  v3au_pkg::t_op                 i_op,
    input  logic [v3au_pkg::CW-1:0]       i_a,
    input  logic [v3au_pkg::CW-1:0]       i_b,
    input  logic [v3au_pkg::CW-1:0]       i_s,
    output logic [2*v3au_pkg::CW-1:0]     o_sq,
    output logic [v3au_pkg::CW-1:0]       o_res,
    output logic [v3au_pkg::CW-1:0]       o_mag,
    output logic                          o_neg,
    output logic                          o_sat
);

    localparam int CW = v3au_pkg::CW;

    logic [CW+1:0]          w_sum;

    // Stage 1: magnitudes and signs, sum of a and b.
    v3au_pkg::t_op          r1_op;
    logic [CW-1:0]          r1_amag;
    logic                   r1_aneg;
    logic [CW-1:0]          r1_smag;
    logic                   r1_sneg;
    logic [CW+1:0]          r1_addmag;
    logic                   r1_addneg;

    // Stage 2: products.
    v3au_pkg::t_op          r2_op;
    logic [2*CW-1:0]        r2_prod;
    logic [CW-1:0]          r2_amag;
    logic                   r2_aneg;
    logic                   r2_pneg;
    logic [CW+1:0]          r2_addmag;
    logic                   r2_addneg;

    logic [2*CW:0]          w_rounded;
    logic [2*CW:0]          w_scaled;
    logic [v3au_pkg::SATW-1:0] w_wm;
    logic                   w_neg;
    v3au_pkg::t_sat         w_s;

    assign w_sum = {{2{i_a[CW-1]}}, i_a} + {{2{i_b[CW-1]}}, i_b};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_op     <= i_op;
            r1_amag   <= v3au_pkg::abs_cw(i_a);
            r1_aneg   <= i_a[CW-1];
            r1_smag   <= v3au_pkg::abs_cw(i_s);
            r1_sneg   <= i_s[CW-1];
            r1_addneg <= w_sum[CW+1];
            r1_addmag <= w_sum[CW+1] ? (~w_sum + (CW+2)'(1)) : w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_op     <= r1_op;
            r2_prod   <= r1_amag * r1_smag;
            o_sq      <= r1_amag * r1_amag;
            r2_amag   <= r1_amag;
            r2_aneg   <= r1_aneg;
            r2_pneg   <= r1_aneg ^ r1_sneg;
            r2_addmag <= r1_addmag;
            r2_addneg <= r1_addneg;
        end
    end

    // Round to nearest with ties away from zero on the magnitude.
    assign w_rounded = {1'b0, r2_prod} + ((2*CW+1)'(1) << (v3au_pkg::FB - 1));
    assign w_scaled  = w_rounded >> v3au_pkg::FB;

    always_comb begin
        case (r2_op)
            v3au_pkg::OP_ADD: begin
                w_wm  = v3au_pkg::SATW'(r2_addmag);
                w_neg = r2_addneg;
            end
            v3au_pkg::OP_SCALE: begin
                w_wm  = w_scaled[v3au_pkg::SATW-1:0];
                w_neg = r2_pneg;
            end
            default: begin
                w_wm  = v3au_pkg::SATW'(r2_amag);
                w_neg = r2_aneg;
            end
        endcase
        w_s = v3au_pkg::sat_mag(w_wm, w_neg);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res <= v3au_pkg::apply_sign(w_s.mag, w_neg);
            o_mag <= w_s.mag;
            o_neg <= w_neg;
            o_sat <= w_s.sat;
        end
    end

endmodule

// ===== hdl/v3au_sqrt.sv =====
// ----------------------------------------------------------------------------
// v3au_sqrt: pipelined integer square root
// Digit-by-digit restoring root, one result bit per stage, with the item
// record carried alongside.
// ----------------------------------------------------------------------------
module v3au_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic [v3au_pkg::RADW-1:0]     i_rad,
    input  v3au_pkg::t_item               i_item,
    output logic                          o_vld,
    output logic [v3au_pkg::ROOTW-1:0]    o_root,
    output v3au_pkg::t_item               o_item
);

    localparam int ROOTW = v3au_pkg::ROOTW;
    localparam int RADW  = v3au_pkg::RADW;
    localparam int RW    = v3au_pkg::RW;

    logic                    r_vld  [0:ROOTW];
    v3au_pkg::t_item         r_item [0:ROOTW];
    logic [ROOTW-1:0]        r_root [0:ROOTW];
    logic [RADW-1:0]         r_rad  [0:ROOTW-1];
    logic [RW-1:0]           r_rem  [0:ROOTW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item[0] <= i_item;
            r_root[0] <= '0;
            r_rad[0]  <= i_rad;
            r_rem[0]  <= '0;
        end
    end

    for (genvar k = 0; k < ROOTW; k++) begin : g_stage
        logic [RW-1:0] w_cand;
        logic [RW-1:0] w_trial;
        logic          w_ge;

        assign w_cand  = {r_rem[k][RW-3:0], r_rad[k][RADW-1 -: 2]};
        assign w_trial = {r_root[k], 2'b01};
        assign w_ge    = (w_cand >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_item[k+1] <= r_item[k];
                r_root[k+1] <= {r_root[k][ROOTW-2:0], w_ge};
            end
        end

        if (k < ROOTW - 1) begin : g_fwd
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rad[k+1] <= r_rad[k] << 2;
                    r_rem[k+1] <= w_ge ? (w_cand - w_trial) : w_cand;
                end
            end
        end
    end

    assign o_vld  = r_vld[ROOTW];
    assign o_root = r_root[ROOTW];
    assign o_item = r_item[ROOTW];

endmodule

// ===== hdl/v3au_div.sv =====
// ----------------------------------------------------------------------------
// v3au_div: pipelined rounding divider for one normalize lane
// Divides |a| scaled up by the fraction and guard bits by the vector length,
// one quotient bit per stage, then rounds to nearest.
// ----------------------------------------------------------------------------
module v3au_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [v3au_pkg::CW-1:0]       i_mag,
    input  logic [v3au_pkg::ROOTW-1:0]    i_den,
    output logic [v3au_pkg::QW-1:0]       o_q
);

    localparam int ROOTW = v3au_pkg::ROOTW;
    localparam int DIVQW = v3au_pkg::DIVQW;
    localparam int QW    = v3au_pkg::QW;
    localparam int G     = v3au_pkg::G;

    logic [ROOTW-1:0]  r_rem [0:DIVQW];
    logic [ROOTW-1:0]  r_den [0:DIVQW];
    logic [DIVQW-1:0]  r_q   [0:DIVQW];
    logic              w_up;

    // The low numerator bits are all zero, so the top bits start the remainder
    // and each step brings down a zero.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {2'b00, i_mag, {(G-1){1'b0}}};
            r_den[0] <= i_den;
            r_q[0]   <= '0;
        end
    end

    for (genvar k = 0; k < DIVQW; k++) begin : g_step
        logic [ROOTW:0] w_cand;
        logic [ROOTW:0] w_diff;
        logic           w_ge;

        assign w_cand = {r_rem[k], 1'b0};
        assign w_ge   = (w_cand >= {1'b0, r_den[k]});
        assign w_diff = w_cand - {1'b0, r_den[k]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= w_ge ? w_diff[ROOTW-1:0] : w_cand[ROOTW-1:0];
                r_den[k+1] <= r_den[k];
                r_q[k+1]   <= {r_q[k][DIVQW-2:0], w_ge};
            end
        end
    end

    assign w_up = ({r_rem[DIVQW], 1'b0} >= {1'b0, r_den[DIVQW]});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_q <= {1'b0, r_q[DIVQW]} + QW'(w_up);
        end
    end

endmodule

// ===== hdl/vector3_arith_unit.sv =====
// ----------------------------------------------------------------------------
// vector3_arith_unit: pipelined 3-D vector add, scale, normalize and pass
// Signed fixed-point components; every result carries the vector, its
// Euclidean magnitude and a status code.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload
//  -------   ------------------   ---------------------------------------------
//  input     i_valid / o_stall    i_opcode, i_a_x/y/z, i_b_x/y/z, i_scale
//  output    o_valid / i_stall    o_res_x/y/z, o_magnitude, o_status
//
//  One beat is accepted per cycle while o_stall is low. A result passes
//  through three front-end stages, two 66-stage square root pipelines (one
//  for the normalize length, one for the magnitude), the 19-stage normalize
//  divider, a merge stage and a squaring stage before the output register.
//  The whole pipeline advances together; a skid register behind the output
//  register takes one more beat when the output stalls, and o_stall is that
//  skid register's occupancy, so it is a flop output.
//  Reset is synchronous and active low and clears only the valid bits.
//
module vector3_arith_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [1:0]                      i_opcode,
    input  logic signed [v3au_pkg::CW-1:0]  i_a_x,
    input  logic signed [v3au_pkg::CW-1:0]  i_a_y,
    input  logic signed [v3au_pkg::CW-1:0]  i_a_z,
    input  logic signed [v3au_pkg::CW-1:0]  i_b_x,
    input  logic signed [v3au_pkg::CW-1:0]  i_b_y,
    input  logic signed [v3au_pkg::CW-1:0]  i_b_z,
    input  logic signed [v3au_pkg::CW-1:0]  i_scale,

    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [v3au_pkg::CW-1:0]  o_res_x,
    output logic signed [v3au_pkg::CW-1:0]  o_res_y,
    output logic signed [v3au_pkg::CW-1:0]  o_res_z,
    output logic [v3au_pkg::CW-1:0]         o_magnitude,
    output logic [1:0]                      o_status
);

    localparam int CW      = v3au_pkg::CW;
    localparam int NLANE   = v3au_pkg::NLANE;
    localparam int SQW     = v3au_pkg::SQW;
    localparam int G       = v3au_pkg::G;
    localparam int ROOTW   = v3au_pkg::ROOTW;
    localparam int RADW    = v3au_pkg::RADW;
    localparam int QW      = v3au_pkg::QW;
    localparam int DIV_LAT = v3au_pkg::DIV_LAT;

    // The pipeline moves whenever the skid register is empty.
    logic                     w_en;

    logic [CW-1:0]            w_a [NLANE];
    logic [CW-1:0]            w_b [NLANE];

    // Front-end control, kept in step with the lanes.
    logic                     r_v1, r_v2, r_v3;
    v3au_pkg::t_op            r_op1, r_op2, r_op3;
    logic [SQW-1:0]           r_sumsq;

    logic [2*CW-1:0]          w_lsq  [NLANE];
    logic [CW-1:0]            w_lres [NLANE];
    logic [CW-1:0]            w_lmag [NLANE];
    logic                     w_lneg [NLANE];
    logic                     w_lsat [NLANE];

    v3au_pkg::t_item          w_it3;
    logic [RADW-1:0]          w_rad1;

    // Length of a for normalize.
    logic                     w_len_vld;
    logic [ROOTW-1:0]         w_len;
    v3au_pkg::t_item          w_len_item;

    logic [QW-1:0]            w_q [NLANE];
    logic                     r_dly_v    [0:DIV_LAT-1];
    v3au_pkg::t_item          r_dly_item [0:DIV_LAT-1];

    // Merge of the lanes into the final vector.
    v3au_pkg::t_item          n_mrg;
    v3au_pkg::t_item          r_mrg;
    logic                     r_mrg_v;

    // Squares of the result magnitudes.
    logic [2*CW-1:0]          r_rsq [NLANE];
    v3au_pkg::t_item          r_sq_item;
    logic                     r_sq_v;
    logic [SQW-1:0]           w_rsum;
    logic [RADW-1:0]          w_rad2;

    logic                     w_last_vld;
    logic [ROOTW-1:0]         w_mag_root;
    v3au_pkg::t_item          w_last_item;
    v3au_pkg::t_out           w_last;

    // Output register and skid register.
    logic                     r_o_vld;
    v3au_pkg::t_out           r_o;
    logic                     r_skid_vld;
    v3au_pkg::t_out           r_skid;
    logic                     w_take;

    assign w_en    = !r_skid_vld;
    assign o_stall = r_skid_vld;

    assign w_a[0] = i_a_x;
    assign w_a[1] = i_a_y;
    assign w_a[2] = i_a_z;
    assign w_b[0] = i_b_x;
    assign w_b[1] = i_b_y;
    assign w_b[2] = i_b_z;

    // ------------------------------------------------------------------
    // Front end: one lane per component.
    // ------------------------------------------------------------------
    for (genvar l = 0; l < NLANE; l++) begin : g_lane
        v3au_lane u_lane (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_op  (v3au_pkg::t_op'(i_opcode)),
            .i_a   (w_a[l]),
            .i_b   (w_b[l]),
            .i_s   (i_scale),
            .o_sq  (w_lsq[l]),
            .o_res (w_lres[l]),
            .o_mag (w_lmag[l]),
            .o_neg (w_lneg[l]),
            .o_sat (w_lsat[l])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_op1   <= v3au_pkg::t_op'(i_opcode);
            r_op2   <= r_op1;
            r_op3   <= r_op2;
            r_sumsq <= SQW'(w_lsq[0]) + SQW'(w_lsq[1]) + SQW'(w_lsq[2]);
        end
    end

    always_comb begin
        w_it3.op   = r_op3;
        w_it3.sat  = w_lsat[0] | w_lsat[1] | w_lsat[2];
        w_it3.zero = (r_op3 == v3au_pkg::OP_NORM) && (r_sumsq == '0);
        for (int i = 0; i < NLANE; i++) begin
            w_it3.res[i] = w_lres[i];
            w_it3.mag[i] = w_lmag[i];
            w_it3.neg[i] = w_lneg[i];
        end
    end

    // The length is taken with guard bits: sqrt(sumsq * 2^(2G)).
    assign w_rad1 = {r_sumsq, {(2*G){1'b0}}};

    v3au_sqrt u_len_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_v3),
        .i_rad   (w_rad1),
        .i_item  (w_it3),
        .o_vld   (w_len_vld),
        .o_root  (w_len),
        .o_item  (w_len_item)
    );

    // ------------------------------------------------------------------
    // Normalize: one divider per component, the item rides a delay line.
    // ------------------------------------------------------------------
    for (genvar l = 0; l < NLANE; l++) begin : g_div
        v3au_div u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_mag (w_len_item.mag[l]),
            .i_den (w_len),
            .o_q   (w_q[l])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_LAT; k++) begin
                r_dly_v[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_dly_v[0] <= w_len_vld;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_dly_v[k] <= r_dly_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dly_item[0] <= w_len_item;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_dly_item[k] <= r_dly_item[k-1];
            end
        end
    end

    // Merge: normalize takes the rounded quotients, a zero vector gives zeros;
    // every other operation already carries its final vector.
    always_comb begin
        v3au_pkg::t_sat w_s;
        n_mrg = r_dly_item[DIV_LAT-1];
        w_s   = '0;
        if (n_mrg.op == v3au_pkg::OP_NORM) begin
            for (int i = 0; i < NLANE; i++) begin
                if (n_mrg.zero) begin
                    n_mrg.res[i] = '0;
                    n_mrg.mag[i] = '0;
                end else begin
                    w_s          = v3au_pkg::sat_mag(v3au_pkg::SATW'(w_q[i]), n_mrg.neg[i]);
                    n_mrg.mag[i] = w_s.mag;
                    n_mrg.res[i] = v3au_pkg::apply_sign(w_s.mag, n_mrg.neg[i]);
                    n_mrg.sat    = n_mrg.sat | w_s.sat;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mrg_v <= 1'b0;
            r_sq_v  <= 1'b0;
        end else if (w_en) begin
            r_mrg_v <= r_dly_v[DIV_LAT-1];
            r_sq_v  <= r_mrg_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mrg     <= n_mrg;
            r_sq_item <= r_mrg;
            for (int i = 0; i < NLANE; i++) begin
                r_rsq[i] <= r_mrg.mag[i] * r_mrg.mag[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Magnitude of the result. The same guard-bit root is used, and the
    // guard bits are dropped afterwards, which gives floor(sqrt(sumsq)).
    // ------------------------------------------------------------------
    assign w_rsum = SQW'(r_rsq[0]) + SQW'(r_rsq[1]) + SQW'(r_rsq[2]);
    assign w_rad2 = {w_rsum, {(2*G){1'b0}}};

    v3au_sqrt u_mag_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_sq_v),
        .i_rad   (w_rad2),
        .i_item  (r_sq_item),
        .o_vld   (w_last_vld),
        .o_root  (w_mag_root),
        .o_item  (w_last_item)
    );

    always_comb begin
        w_last.res       = w_last_item.res;
        w_last.magnitude = w_mag_root[G +: CW];
        if (w_last_item.sat) begin
            w_last.status = v3au_pkg::ST_SAT;
        end else if (w_last_item.zero) begin
            w_last.status = v3au_pkg::ST_ZERO;
        end else begin
            w_last.status = v3au_pkg::ST_OK;
        end
    end

    // ------------------------------------------------------------------
    // Output register with skid. While the skid register is full the
    // pipeline holds, so the last stage keeps its beat.
    // ------------------------------------------------------------------
    assign w_take = r_o_vld && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld    <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_take) begin
                r_skid_vld <= 1'b0;
            end
        end else if (w_last_vld) begin
            if (!r_o_vld || w_take) begin
                r_o_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (w_take) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_take) begin
                r_o <= r_skid;
            end
        end else if (w_last_vld) begin
            if (!r_o_vld || w_take) begin
                r_o <= w_last;
            end else begin
                r_skid <= w_last;
            end
        end
    end

    assign o_valid     = r_o_vld;
    assign o_res_x     = r_o.res[0];
    assign o_res_y     = r_o.res[1];
    assign o_res_z     = r_o.res[2];
    assign o_magnitude = r_o.magnitude;
    assign o_status    = r_o.status;

endmodule
